// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. The bodies refer to clk and arst_n of the
// module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_HOLDS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/slfb_pkg.sv =====
package slfb_pkg;

	localparam int FRAME_LEN           = 4;
	localparam int CFG_INDEX_W         = 2;
	localparam int CFG_DATA_W          = 20;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hA5;

	localparam logic DEST_REMOTE = 1'b0;
	localparam logic DEST_POOL   = 1'b1;

	// Register map of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_HEATER_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_FORCE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TEMP   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERRUN_TICKS = 2'd3;
	localparam logic [19:0]            OVERRUN_RESET     = 20'd120000;

	// Frame types and values that the bridge acts upon.
	localparam logic [7:0] TYPE_TEMP    = 8'h06;
	localparam logic [7:0] TYPE_STATUS  = 8'h08;
	localparam logic [7:0] TYPE_HOURS   = 8'h0B;
	localparam logic [7:0] TYPE_HEATER  = 8'h01;
	localparam logic [7:0] TYPE_FILTER  = 8'h02;
	localparam logic [7:0] VAL_IDLE     = 8'h00;
	localparam logic [7:0] VAL_FILTER   = 8'h03;

	// Codes reported on the pool_status field.
	localparam logic [1:0] PSTAT_IDLE      = 2'd1;
	localparam logic [1:0] PSTAT_FILTER_ON = 2'd2;
	localparam logic [1:0] PSTAT_UNKNOWN   = 2'd3;

	typedef enum logic [1:0] {
		KIND_POOL   = 2'd0,
		KIND_REMOTE = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] temp_half_deg;
		logic       temp_valid;
		logic [1:0] pool_status;
		logic [7:0] filter_hours;
		logic       heater_on;
	} status_t;

	// One queued job: a relayed pool byte, or a rebuilt remote frame.
	typedef struct packed {
		logic       is_remote;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic       frame_error;
		status_t    status;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

endpackage

// ===== rtl/core/slfb_in_if.sv =====
interface slfb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] in_byte;

	modport source (output valid, output kind, output in_byte, input ready);
	modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

// ===== rtl/core/slfb_out_if.sv =====
interface slfb_out_if;
	logic       valid;
	logic       ready;
	logic       dest;
	logic [7:0] out_byte;
	logic       last;
	logic [7:0] temp_half_deg;
	logic       temp_valid;
	logic [1:0] pool_status;
	logic [7:0] filter_hours;
	logic       heater_on;
	logic       frame_error;

	modport source (output valid, output dest, output out_byte, output last,
		output temp_half_deg, output temp_valid, output pool_status,
		output filter_hours, output heater_on, output frame_error, input ready);
	modport sink (input valid, input dest, input out_byte, input last,
		input temp_half_deg, input temp_valid, input pool_status,
		input filter_hours, input heater_on, input frame_error, output ready);
endinterface

// ===== rtl/core/slfb_front.sv =====
module slfb_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [slfb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [slfb_pkg::CFG_DATA_W-1:0]  cfg_data,
	slfb_in_if.sink                        item,
	input  slfb_pkg::queue_stat_t          q_stat,
	output logic                           push,
	output slfb_pkg::entry_t               push_entry
);
	import slfb_pkg::*;

	localparam logic [1:0] LAST_COUNT = 2'(FRAME_LEN - 1);

	typedef struct packed {
		logic       in_frame;
		logic [1:0] count;
		logic       complete;
		logic       wr_en;
		logic       wr_idx;
	} frame_step_t;

	function automatic frame_step_t frame_step(logic in_frame, logic [1:0] count,
		logic [7:0] b);
		frame_step_t r;
		r.in_frame = in_frame;
		r.count    = count;
		r.complete = 1'b0;
		r.wr_en    = 1'b0;
		r.wr_idx   = ~count[0];
		if (!in_frame) begin
			if (b == SYNC_BYTE) begin
				r.in_frame = 1'b1;
				r.count    = 2'd1;
			end
		end else if (count >= LAST_COUNT) begin
			r.in_frame = 1'b0;
			r.count    = 2'd0;
			r.complete = 1'b1;
		end else begin
			r.wr_en = 1'b1;
			r.count = count + 2'd1;
		end
		return r;
	endfunction

	logic        heater_enable_q, filter_force_q;
	logic [7:0]  target_q;
	logic [19:0] overrun_ticks_q;

	logic        p_in_q, r_in_q;
	logic [1:0]  p_cnt_q, r_cnt_q;
	logic [7:0]  p_bytes_q [2];
	logic [7:0]  r_bytes_q [2];

	logic [7:0]  temp_q, temp_d, hours_q, hours_d;
	logic        seen_q, seen_d, heat_q, heat_d, ovr_act_q, ovr_act_d;
	logic [1:0]  pstat_q, pstat_d;
	logic [19:0] ovr_cnt_q, ovr_cnt_d;

	frame_step_t ps, rs;
	logic        acc, p_take, r_take, p_good, r_good, ferr;
	logic [7:0]  p_sum, r_sum, v_out;
	kind_t       kind;

	assign item.ready = !q_stat.full;
	assign acc        = item.valid && item.ready;
	assign kind       = kind_t'(item.kind);
	assign p_take     = acc && (kind == KIND_POOL);
	assign r_take     = acc && (kind == KIND_REMOTE);

	assign ps    = frame_step(p_in_q, p_cnt_q, item.in_byte);
	assign rs    = frame_step(r_in_q, r_cnt_q, item.in_byte);
	assign p_sum = 8'(SYNC_BYTE + p_bytes_q[0] + p_bytes_q[1]);
	assign r_sum = 8'(SYNC_BYTE + r_bytes_q[0] + r_bytes_q[1]);
	assign p_good = p_take && ps.complete && (p_sum == item.in_byte);
	assign r_good = r_take && rs.complete && (r_sum == item.in_byte);
	assign ferr   = p_take && ps.complete && (p_sum != item.in_byte);

	always_comb begin
		temp_d    = temp_q;
		seen_d    = seen_q;
		pstat_d   = pstat_q;
		hours_d   = hours_q;
		heat_d    = heat_q;
		ovr_act_d = ovr_act_q;
		ovr_cnt_d = ovr_cnt_q;
		v_out     = r_bytes_q[1];
		if (p_good) begin
			case (p_bytes_q[0])
				TYPE_TEMP: begin
					temp_d = p_bytes_q[1];
					seen_d = 1'b1;
				end
				TYPE_STATUS: begin
					if (p_bytes_q[1] == VAL_IDLE) begin
						pstat_d = PSTAT_IDLE;
					end else if (p_bytes_q[1] == VAL_FILTER) begin
						pstat_d = PSTAT_FILTER_ON;
					end else begin
						pstat_d = PSTAT_UNKNOWN;
					end
				end
				TYPE_HOURS: hours_d = p_bytes_q[1];
				default: ;
			endcase
		end
		if (r_good) begin
			if (r_bytes_q[0] == TYPE_HEATER && r_bytes_q[1] == 8'h00 && heater_enable_q) begin
				if (seen_q) begin
					if (temp_q < target_q) begin
						heat_d = 1'b1;
					end else if (temp_q > target_q) begin
						heat_d = 1'b0;
					end
				end
				v_out = {7'd0, heat_d};
				if (heat_d) begin
					ovr_act_d = 1'b1;
					ovr_cnt_d = overrun_ticks_q;
				end
			end else if (r_bytes_q[0] == TYPE_FILTER && r_bytes_q[1] == 8'h00 &&
				(heater_enable_q || ovr_act_q || filter_force_q)) begin
				v_out = 8'h01;
			end
		end
		if (acc && kind == KIND_TICK && ovr_act_q) begin
			if (ovr_cnt_q <= 20'd1) begin
				ovr_cnt_d = '0;
				ovr_act_d = 1'b0;
			end else begin
				ovr_cnt_d = ovr_cnt_q - 20'd1;
			end
		end
	end

	assign push = p_take || r_good;

	always_comb begin
		push_entry.is_remote            = r_take;
		push_entry.byte_a               = r_take ? r_bytes_q[0] : item.in_byte;
		push_entry.byte_b               = v_out;
		push_entry.frame_error          = ferr;
		push_entry.status.temp_half_deg = temp_d;
		push_entry.status.temp_valid    = seen_d;
		push_entry.status.pool_status   = pstat_d;
		push_entry.status.filter_hours  = hours_d;
		push_entry.status.heater_on     = heat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_enable_q <= 1'b0;
			filter_force_q  <= 1'b0;
			target_q        <= '0;
			overrun_ticks_q <= OVERRUN_RESET;
			p_in_q          <= 1'b0;
			p_cnt_q         <= '0;
			r_in_q          <= 1'b0;
			r_cnt_q         <= '0;
			temp_q          <= '0;
			seen_q          <= 1'b0;
			pstat_q         <= '0;
			hours_q         <= '0;
			heat_q          <= 1'b0;
			ovr_act_q       <= 1'b0;
			ovr_cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HEATER_ENABLE: heater_enable_q <= cfg_data[0];
					REG_FILTER_FORCE:  filter_force_q  <= cfg_data[0];
					REG_TARGET_TEMP:   target_q        <= cfg_data[7:0];
					REG_OVERRUN_TICKS: overrun_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (p_take) begin
				p_in_q  <= ps.in_frame;
				p_cnt_q <= ps.count;
			end
			if (r_take) begin
				r_in_q  <= rs.in_frame;
				r_cnt_q <= rs.count;
			end
			temp_q    <= temp_d;
			seen_q    <= seen_d;
			pstat_q   <= pstat_d;
			hours_q   <= hours_d;
			heat_q    <= heat_d;
			ovr_act_q <= ovr_act_d;
			ovr_cnt_q <= ovr_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (p_take && ps.wr_en) begin
			p_bytes_q[ps.wr_idx] <= item.in_byte;
		end
		if (r_take && rs.wr_en) begin
			r_bytes_q[rs.wr_idx] <= item.in_byte;
		end
	end

endmodule

// ===== rtl/core/slfb_queue.sv =====
module slfb_queue #(
	parameter int DEPTH = slfb_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  slfb_pkg::entry_t      push_entry,
	input  logic                  pop,
	output slfb_pkg::queue_stat_t stat,
	output slfb_pkg::entry_t      head
);
	import slfb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == CNT_FULL);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/core/slfb_back.sv =====
module slfb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slfb_pkg::queue_stat_t q_stat,
	input  slfb_pkg::entry_t      head,
	output logic                  pop,
	slfb_out_if.source            result
);
	import slfb_pkg::*;

	localparam logic [1:0] BEAT_SYNC  = 2'd0;
	localparam logic [1:0] BEAT_TYPE  = 2'd1;
	localparam logic [1:0] BEAT_VALUE = 2'd2;
	localparam logic [1:0] BEAT_CSUM  = 2'd3;

	logic       out_valid_q;
	logic [1:0] beat_q;
	logic       load, beat_last;
	logic [7:0] beat_byte;

	assign load      = !out_valid_q || result.ready;
	assign beat_last = !head.is_remote || (beat_q == BEAT_CSUM);
	assign pop       = load && q_stat.valid && beat_last;

	always_comb begin
		if (!head.is_remote) begin
			beat_byte = head.byte_a;
		end else begin
			case (beat_q)
				BEAT_SYNC:  beat_byte = SYNC_BYTE;
				BEAT_TYPE:  beat_byte = head.byte_a;
				BEAT_VALUE: beat_byte = head.byte_b;
				default:    beat_byte = 8'(SYNC_BYTE + head.byte_a + head.byte_b);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= BEAT_SYNC;
		end else if (load) begin
			out_valid_q <= q_stat.valid;
			if (q_stat.valid) begin
				beat_q <= beat_last ? BEAT_SYNC : beat_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_stat.valid) begin
			result.dest          <= head.is_remote ? DEST_POOL : DEST_REMOTE;
			result.out_byte      <= beat_byte;
			result.last          <= beat_last;
			result.temp_half_deg <= head.status.temp_half_deg;
			result.temp_valid    <= head.status.temp_valid;
			result.pool_status   <= head.status.pool_status;
			result.filter_hours  <= head.status.filter_hours;
			result.heater_on     <= head.status.heater_on;
			result.frame_error   <= head.frame_error;
		end
	end

	assign result.valid = out_valid_q;

endmodule

// ===== rtl/core/spa_link_frame_bridge.sv =====
// A byte from the pool is written into the queue, then into the output register.
// A good remote frame gives four output bytes on that path after its checksum byte.
// Throughput: one input transaction per cycle while the queue is not full; output is
// one byte per cycle while result.ready allows, set by the single output register.
// Reset (arst_n low, asynchronous): framing, stored status, overrun and queue are cleared,
// the overrun length returns to 120000 ticks and all host switches go off.
`include "assert_macros.svh"

module spa_link_frame_bridge #(
	parameter int QUEUE_DEPTH = slfb_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [slfb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [slfb_pkg::CFG_DATA_W-1:0]  cfg_data,
	slfb_in_if.sink                          item,
	slfb_out_if.source                       result
);
	import slfb_pkg::*;

	// The front end takes one transaction per cycle while the queue is not full, tracks
	// the framing of both links, updates the stored pool status and the thermostat, and
	// turns every transaction that produces output into a single queue entry. Ticks and
	// dropped remote frames only change state.
	queue_stat_t q_stat;
	entry_t      push_entry, head;
	logic        push, pop;

	slfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// The queue decouples the two sides, so the input keeps flowing while a
	// rebuilt remote frame is still being sent out byte by byte.
	slfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.stat       (q_stat),
		.head       (head)
	);

	// The back end expands each entry into one byte for the remote, or the four
	// bytes of a frame for the pool, carrying the status snapshot of the entry.
	slfb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

	// The front end must never push into a full queue.
	`ASSERT_HOLDS(a_push_not_full, !push || !q_stat.full, "push into full queue")
	// The back end only pops an entry that is there.
	`ASSERT_HOLDS(a_pop_valid, !pop || q_stat.valid, "pop from empty queue")
	// A byte relayed to the remote is always the only result of its transaction.
	`ASSERT_HOLDS(a_remote_last, !result.valid || result.dest != DEST_REMOTE || result.last,
		"relayed pool byte without last")
	// An entry pushed into an empty queue is visible in the next cycle.
	`ASSERT_NEXT(a_push_seen, push && !q_stat.valid, q_stat.valid, "pushed entry lost")

endmodule
